// ----- src/gspd_pkg.sv -----
// package for the gauge stepper pointer driver: codes, widths and divider tables
`default_nettype none

package gspd_pkg;

  // item codes
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_SET  = 2'd1,
    MODE_HOME = 2'd2
  } mode_e;

  localparam int ChannelsDef = 6;
  localparam int OutW        = 6;
  localparam int PosW        = 16;
  localparam int DivW        = 7;
  localparam int ChW         = 3;
  localparam int NumLimits   = 12;

  localparam logic [OutW-1:0] MaskReset = 6'd8;
  localparam logic [DivW-1:0] CountTop  = 7'd127;

  // distance thresholds, largest first
  localparam logic [PosW-1:0] DistLimit [NumLimits] = '{
    16'd480, 16'd360, 16'd240, 16'd180, 16'd120, 16'd80,
    16'd60,  16'd45,  16'd30,  16'd20,  16'd12,  16'd6
  };

  localparam logic [DivW-1:0] FastDiv [NumLimits+1] = '{
    7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd10, 7'd15, 7'd25, 7'd35
  };

  localparam logic [DivW-1:0] SlowDiv [NumLimits+1] = '{
    7'd5, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100,
    7'd110, 7'd120
  };

  // thresholds fall monotonically, so the number of limits at or above the
  // distance is the table row
  function automatic logic [DivW-1:0] pick_divider(input logic [PosW-1:0] span,
                                                   input logic slow);
    logic [3:0] k;
    k = '0;
    for (int i = 0; i < NumLimits; i++) begin
      if (span <= DistLimit[i]) k = k + 4'd1;
    end
    return slow ? SlowDiv[k] : FastDiv[k];
  endfunction

endpackage

`default_nettype wire

// ----- src/gauge_stepper_pointer_driver_top.sv -----
// gauge stepper pointer driver: per-channel step generation for gauge motors
//
// Input channel (in_valid_i / in_stall_o) carries one item per transfer: a
// millisecond tick, a set-target command for one channel, or a home command
// for all channels. Output channel (out_valid_o / out_stall_i) returns one
// result per item: the step pulses of a tick, the direction and moving bits
// of every channel, and the position of the channel named in the item.
// The result is registered: the result of an item accepted at one edge is
// valid after that edge. One item can be accepted every cycle while no held
// result is stalled; the channel state and the result register are both updated
// in the accepting cycle. When the receiver stalls, the result register holds and
// further items are refused (in_stall_o high) until the held result is taken.
// Reset clears positions, remaining counts, dividers and counters, points
// every channel downward, and sets the slow profile mask to channel 3 only.
// The user must write the mask through cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
`default_nettype none

module gauge_stepper_pointer_driver_top #(
  parameter int CHANNELS = gspd_pkg::ChannelsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [gspd_pkg::OutW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                mode_i,
  input  wire logic [gspd_pkg::ChW-1:0]  channel_i,
  input  wire logic [gspd_pkg::PosW-1:0] target_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [gspd_pkg::OutW-1:0]      step_pulses_o,
  output logic [gspd_pkg::OutW-1:0]      directions_o,
  output logic [gspd_pkg::OutW-1:0]      moving_o,
  output logic [gspd_pkg::PosW-1:0]      channel_position_o
);

  import gspd_pkg::*;

  localparam int CmpW = ($clog2(CHANNELS) > ChW) ? $clog2(CHANNELS) : ChW;
  localparam logic [OutW-1:0] LiveMask =
    (CHANNELS >= OutW) ? {OutW{1'b1}} : OutW'((1 << CHANNELS) - 1);

  // channel state
  logic [PosW-1:0]     pos_q [CHANNELS];
  logic [PosW-1:0]     pos_d [CHANNELS];
  logic [PosW-1:0]     rem_q [CHANNELS];
  logic [PosW-1:0]     rem_d [CHANNELS];
  logic [DivW-1:0]     div_q [CHANNELS];
  logic [DivW-1:0]     div_d [CHANNELS];
  logic [DivW-1:0]     cnt_q [CHANNELS];
  logic [DivW-1:0]     cnt_d [CHANNELS];
  logic [CHANNELS-1:0] down_q, down_d;
  logic [CHANNELS-1:0] pulse;
  logic [OutW-1:0]     mask_q;

  // result register
  logic                out_valid_q;
  logic [OutW-1:0]     pulses_q, pulses_d;
  logic [OutW-1:0]     dirs_q, dirs_d;
  logic [OutW-1:0]     mov_q, mov_d;
  logic [PosW-1:0]     chpos_q, chpos_d;

  logic                in_accept;
  logic [CHANNELS-1:0] hit;
  logic [CHANNELS-1:0] slow_vec;
  logic [PosW-1:0]     pos_sel;
  logic                slow_sel;
  logic                set_down;
  logic [PosW-1:0]     span;
  logic [DivW-1:0]     new_div;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // profile mask covers the first six channels only
  for (genvar g = 0; g < CHANNELS; g++) begin : g_slow
    if (g < OutW) begin : g_mask
      assign slow_vec[g] = mask_q[g];
    end else begin : g_fast
      assign slow_vec[g] = 1'b0;
    end
  end

  // addressed channel and its target distance
  always_comb begin
    pos_sel  = '0;
    slow_sel = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      hit[c] = (CmpW'(channel_i) == CmpW'(c));
      if (hit[c]) begin
        pos_sel  = pos_q[c];
        slow_sel = slow_vec[c];
      end
    end
    set_down = (target_i < pos_sel);
    span     = set_down ? (pos_sel - target_i) : (target_i - pos_sel);
    new_div  = pick_divider(span, slow_sel);
  end

  // next channel state for the item
  always_comb begin
    pos_d  = pos_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    down_d = down_q;
    pulse  = '0;
    case (mode_e'(mode_i))
      MODE_TICK: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (rem_q[c] != '0) begin
            if (cnt_q[c] >= div_q[c]) begin
              pulse[c] = 1'b1;
              cnt_d[c] = '0;
              rem_d[c] = rem_q[c] - PosW'(1);
              if (down_q[c]) begin
                if (pos_q[c] != '0) pos_d[c] = pos_q[c] - PosW'(1);
              end else if (pos_q[c] != {PosW{1'b1}}) begin
                pos_d[c] = pos_q[c] + PosW'(1);
              end
            end else if (cnt_q[c] != CountTop) begin
              cnt_d[c] = cnt_q[c] + DivW'(1);
            end
          end else begin
            cnt_d[c] = '0;
          end
        end
      end
      MODE_SET: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (hit[c]) begin
            down_d[c] = set_down;
            rem_d[c]  = span;
            div_d[c]  = new_div;
          end
        end
      end
      MODE_HOME: begin
        for (int c = 0; c < CHANNELS; c++) begin
          down_d[c] = 1'b1;
          rem_d[c]  = pos_q[c];
          div_d[c]  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // result fields, first six channels
  for (genvar g = 0; g < OutW; g++) begin : g_out
    if (g < CHANNELS) begin : g_live
      assign pulses_d[g] = pulse[g];
      assign dirs_d[g]   = down_d[g];
      assign mov_d[g]    = (rem_d[g] != '0);
    end else begin : g_none
      assign pulses_d[g] = 1'b0;
      assign dirs_d[g]   = 1'b0;
      assign mov_d[g]    = 1'b0;
    end
  end

  always_comb begin
    chpos_d = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (hit[c]) chpos_d = pos_d[c];
    end
  end

  // state registers, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pos_q[c] <= '0;
        rem_q[c] <= '0;
        div_q[c] <= '0;
        cnt_q[c] <= '0;
      end
      down_q <= '1;
    end else if (in_accept) begin
      pos_q  <= pos_d;
      rem_q  <= rem_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
      down_q <= down_d;
    end
  end

  // profile mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskReset;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pulses_q <= pulses_d;
      dirs_q   <= dirs_d;
      mov_q    <= mov_d;
      chpos_q  <= chpos_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign step_pulses_o      = pulses_q;
  assign directions_o       = dirs_q;
  assign moving_o           = mov_q;
  assign channel_position_o = chpos_q;

  // only a tick produces step pulses
  a_pulse_only_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (mode_i != MODE_TICK)) |=> (step_pulses_o == '0))
    else $error("step pulse on a non-tick item");

  // home points every channel downward
  a_home_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (mode_i == MODE_HOME)) |=> (directions_o == LiveMask))
    else $error("home left a channel pointing upward");

  // a taken result with no new transfer empties the result register
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !in_accept) |=> !out_valid_o)
    else $error("result repeated after transfer");

endmodule

`default_nettype wire
